// ----- rtl/ascr_pkg.sv -----
package ascr_pkg;

  localparam int MAX_CAPTURE = 131072;
  localparam int SAMPLE_BITS = 24;
  localparam int MIN_LENGTH  = 4;
  localparam int RESET_LENGTH = 4800;

  localparam int ADDR_W  = $clog2(MAX_CAPTURE);
  localparam int COUNT_W = $clog2(MAX_CAPTURE + 1);

  localparam int LEN_REG_W  = 18;
  localparam int THR_REG_W  = 17;
  localparam int RAND_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [ADDR_W-1:0]      addr_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STUTTER_LENGTH    = 2'd0,
    REG_TRIGGER_THRESHOLD = 2'd1,
    REG_MONO_MODE         = 2'd2
  } reg_index_t;

  // store access for one accepted item
  typedef struct packed {
    logic    we;
    addr_t   waddr;
    sample_t wdata_left;
    sample_t wdata_right;
    logic    re;
    addr_t   raddr;
  } ram_req_t;

  // what the output stage needs besides the store data
  typedef struct packed {
    logic    hit;
    logic    mono;
    sample_t left;
    sample_t right;
  } stage_t;

  function automatic count_t clamp_length(input logic [LEN_REG_W-1:0] len);
    count_t res;
    if (int'(len) > MAX_CAPTURE) res = COUNT_W'(MAX_CAPTURE);
    else if (int'(len) < MIN_LENGTH) res = COUNT_W'(MIN_LENGTH);
    else res = COUNT_W'(len);
    return res;
  endfunction

endpackage

// ----- rtl/ascr_if.sv -----
interface ascr_frame_if;
  import ascr_pkg::*;
  logic                valid;
  logic                ready;
  sample_t             left_in;
  sample_t             right_in;
  logic [RAND_W-1:0]   rand_value;
  modport source (output valid, left_in, right_in, rand_value, input ready);
  modport sink (input valid, left_in, right_in, rand_value, output ready);
endinterface

interface ascr_result_if;
  import ascr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  logic    stutter_active;
  modport source (output valid, left_out, right_out, stutter_active, input ready);
  modport sink (input valid, left_out, right_out, stutter_active, output ready);
endinterface

interface ascr_cfg_if;
  import ascr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/ascr_ram.sv -----
module ascr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ascr_ctrl.sv -----
module ascr_ctrl
  import ascr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ascr_cfg_if.sink          cfg,
  input  logic              accept,
  input  sample_t           left_in,
  input  sample_t           right_in,
  input  logic [RAND_W-1:0] rand_value,
  output ram_req_t          ram_req,
  output stage_t            stage
);

  logic [LEN_REG_W-1:0] stutter_length;
  logic [THR_REG_W-1:0] trigger_threshold;
  logic                 mono_mode;

  count_t capture_count, capture_count_next;
  count_t frames_remaining, frames_remaining_next;
  logic   replay_active, replay_active_next;

  count_t               len;
  count_t               count_a;
  count_t               frames_a;
  count_t               offset;
  logic [COUNT_W:0]     sum;
  logic [COUNT_W:0]     idx;
  logic                 store_room;
  logic                 trigger;
  logic                 replay_a;
  sample_t              right_eff;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      stutter_length    <= LEN_REG_W'(RESET_LENGTH);
      trigger_threshold <= '0;
      mono_mode         <= 1'b0;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_STUTTER_LENGTH:    stutter_length    <= cfg.data[LEN_REG_W-1:0];
        REG_TRIGGER_THRESHOLD: trigger_threshold <= cfg.data[THR_REG_W-1:0];
        REG_MONO_MODE:         mono_mode         <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len        = clamp_length(stutter_length);
    right_eff  = mono_mode ? left_in : right_in;
    store_room = int'(capture_count) < MAX_CAPTURE;

    // capture while idle
    count_a = capture_count;
    if (!replay_active && store_room) count_a = capture_count + 1'b1;

    trigger  = !replay_active && ({1'b0, rand_value} < trigger_threshold) && (count_a >= len);
    replay_a = replay_active || trigger;
    frames_a = trigger ? len : frames_remaining;

    // replay index: last len captured frames, walked in order
    offset = (frames_a == '0) ? '0 : len - frames_a;
    sum    = {1'b0, count_a} + {1'b0, offset};
    idx    = sum - {1'b0, len};

    ram_req.we          = accept && !replay_active && store_room;
    ram_req.waddr       = capture_count[ADDR_W-1:0];
    ram_req.wdata_left  = left_in;
    ram_req.wdata_right = right_eff;

    stage.hit   = replay_a && (frames_a <= len) && (sum >= {1'b0, len});
    stage.mono  = mono_mode;
    stage.left  = left_in;
    stage.right = right_eff;

    ram_req.re    = accept && stage.hit;
    ram_req.raddr = idx[ADDR_W-1:0];

    capture_count_next    = count_a;
    frames_remaining_next = frames_a;
    replay_active_next    = replay_a;
    if (replay_a) begin
      if (frames_a <= count_t'(1)) begin
        frames_remaining_next = '0;
        replay_active_next    = 1'b0;
        capture_count_next    = '0;
      end else begin
        frames_remaining_next = frames_a - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_count    <= '0;
      frames_remaining <= '0;
      replay_active    <= 1'b0;
    end else if (accept) begin
      capture_count    <= capture_count_next;
      frames_remaining <= frames_remaining_next;
      replay_active    <= replay_active_next;
    end
  end

endmodule

// ----- rtl/audio_stutter_capture_replay_top.sv -----
// stereo stutter: capture and replay of audio frames
//
// audio carries one frame per item (left_in, right_in, rand_value); result
// returns one item per frame (left_out, right_out, stutter_active), in order.
// cfg writes stutter_length (0), trigger_threshold (1) and mono_mode (2);
// it is ready whenever rst is low, and writes belong to times when no frame
// is in flight.
//
// an accepted item passes the capture store read (two one-port-write,
// one-port-read rams, one per channel, registered read data) and then the
// output register. one item is taken every cycle while result does not
// stall; the store sees at most one write and one read per item.
//
// reset clears the capture count, the replay state and the registers to
// their defaults; audio and cfg are not ready while rst is high. store
// contents are not cleared, replay only reads entries captured since the
// last count reset.
// when result stalls, the output register holds, the read stage fills, and
// then audio.ready drops until the output moves again.
module audio_stutter_capture_replay_top
  import ascr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ascr_frame_if.sink    audio,
  ascr_result_if.source result,
  ascr_cfg_if.sink      cfg
);

  ram_req_t ram_req;
  stage_t   stage_in;
  stage_t   stage;
  logic     stage_valid;
  sample_t  rd_left;
  sample_t  rd_right;
  logic     out_free;
  logic     accept;

  assign out_free    = !result.valid || result.ready;
  assign audio.ready = !rst && (!stage_valid || out_free);
  assign accept      = audio.valid && audio.ready;

  ascr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .left_in    (audio.left_in),
    .right_in   (audio.right_in),
    .rand_value (audio.rand_value),
    .ram_req    (ram_req),
    .stage      (stage_in)
  );

  ascr_ram #(.DEPTH(MAX_CAPTURE), .WIDTH(SAMPLE_BITS)) u_left_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata_left),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_left)
  );

  ascr_ram #(.DEPTH(MAX_CAPTURE), .WIDTH(SAMPLE_BITS)) u_right_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata_right),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_right)
  );

  // read stage, lines up with the ram data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (audio.ready) begin
      stage_valid <= audio.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stage <= stage_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_valid) begin
      result.left_out       <= stage.hit ? rd_left : stage.left;
      result.right_out      <= stage.hit ? (stage.mono ? rd_left : rd_right) : stage.right;
      result.stutter_active <= stage.hit;
    end
  end

  // capture and replay never touch the same entry in one cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("store write and read at the same entry");

  // with the output register empty, audio is always ready for a new frame
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> audio.ready)
    else $error("input stalled with empty output register");

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  // a stalled replay item keeps its ram data
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && stage.hit && !out_free) |=> ($stable(rd_left) && $stable(rd_right)))
    else $error("store read data changed while stalled");

endmodule
